/* rtl/ita_pkg.sv */
package ita_pkg;

    // Data word and text sizing
    localparam int WORD_BITS = 64;
    localparam int MAX_CHARS = 64;
    localparam int MAX_PREC  = MAX_CHARS - 3;

    // Octal needs the most digits of the three radixes
    localparam int NDIG   = (WORD_BITS + 2) / 3;
    localparam int ND_W   = $clog2(NDIG + 1);
    localparam int LZ_W   = $clog2(NDIG);
    localparam int BIT_W  = $clog2(WORD_BITS);
    localparam int CNT_W  = $clog2(MAX_CHARS + 1);
    localparam int PREC_W = 6;

    // Radix codes
    localparam logic [1:0] BASE_OCT = 2'd0;
    localparam logic [1:0] BASE_DEC = 2'd1;
    localparam logic [1:0] BASE_HEX = 2'd2;

    // Flag bit positions
    localparam int FL_ZERO  = 0;
    localparam int FL_SIGN  = 1;
    localparam int FL_PLUS  = 2;
    localparam int FL_SPACE = 3;
    localparam int FL_LEFT  = 4;
    localparam int FL_PREF  = 5;
    localparam int FL_LOWER = 6;

    // ASCII codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_X  = 8'h78;

    // Converter to emitter: format of the current item and the leading digit
    typedef struct packed {
        logic              start;
        logic [ND_W-1:0]   nd;
        logic [CNT_W-1:0]  width;
        logic [PREC_W-1:0] prec;
        logic              zero_pad;
        logic              left;
        logic              lower;
        logic              has_sign;
        logic [7:0]        sign_ch;
        logic [1:0]        pre_len;
        logic [3:0]        top_digit;
    } ita_fmt_t;

    // Emitter to converter
    typedef struct packed {
        logic pop;
        logic done;
    } ita_emit_stat_t;

    // One digit to its ASCII character
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
        logic [7:0] r;
        if (d < 4'd10)
        begin
            r = CH_ZERO + {4'd0, d};
        end
        else if (lower)
        begin
            r = CH_LO_A + {4'd0, d} - 8'd10;
        end
        else
        begin
            r = CH_UP_A + {4'd0, d} - 8'd10;
        end
        return r;
    endfunction

endpackage

/* rtl/ita_in_if.sv */
interface ita_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [1:0]  base_select;
    logic [6:0]  min_width;
    logic [5:0]  min_digits;
    logic [6:0]  format_flags;

    modport source (output valid, output value, output base_select, output min_width,
                    output min_digits, output format_flags, input ready);
    modport sink (input valid, input value, input base_select, input min_width,
                  input min_digits, input format_flags, output ready);
endinterface

/* rtl/ita_out_if.sv */
interface ita_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink (input valid, input out_char, input last_char, output ready);
endinterface

/* rtl/ita_convert.sv */
module ita_convert
(
    input  logic                      clk,
    input  logic                      rst_n,
    ita_in_if.sink                    din,
    input  ita_pkg::ita_emit_stat_t   stat,
    output ita_pkg::ita_fmt_t         fmt
);

    localparam logic [1:0] CV_IDLE = 2'd0;
    localparam logic [1:0] CV_CONV = 2'd1;
    localparam logic [1:0] CV_NORM = 2'd2;
    localparam logic [1:0] CV_WAIT = 2'd3;

    logic [1:0]                        state_reg, state_next;
    logic [ita_pkg::BIT_W-1:0]         bit_cnt_reg, bit_cnt_next;
    logic [ita_pkg::LZ_W-1:0]          lz_reg, lz_next;
    logic [ita_pkg::WORD_BITS-1:0]     mag_reg, mag_next;
    logic [3:0]                        dig_reg [ita_pkg::NDIG];
    logic [3:0]                        dig_next [ita_pkg::NDIG];
    logic [1:0]                        sel_reg;
    logic [ita_pkg::CNT_W-1:0]         width_reg;
    logic [ita_pkg::PREC_W-1:0]        prec_reg;
    logic                              zero_reg, left_reg, lower_reg, has_sign_reg;
    logic [7:0]                        sign_ch_reg;
    logic                              fmt_pref_reg;

    logic                              accept;
    logic [ita_pkg::WORD_BITS-1:0]     mag_in;
    logic                              neg;
    logic                              is_oct, is_dec, is_hex;
    logic [3:0]                        adj [ita_pkg::NDIG];
    logic [3:0]                        dig_step [ita_pkg::NDIG];
    logic [3:0]                        dig_up [ita_pkg::NDIG];
    logic                              norm_done;
    logic [1:0]                        pre_len;

    assign din.ready = (state_reg == CV_IDLE);
    assign accept    = din.valid && din.ready;

    // Sign and magnitude of the incoming word
    assign mag_in = din.value[ita_pkg::WORD_BITS-1:0];
    assign neg    = din.format_flags[ita_pkg::FL_SIGN] && mag_in[ita_pkg::WORD_BITS-1];

    assign is_oct = (sel_reg == ita_pkg::BASE_OCT);
    assign is_dec = (sel_reg == ita_pkg::BASE_DEC);
    assign is_hex = !is_oct && !is_dec;

    // One conversion step: shift-and-add-3 for decimal, plain shift otherwise
    always_comb
    begin
        for (int i = 0; i < ita_pkg::NDIG; i++)
        begin
            adj[i] = (is_dec && dig_reg[i] >= 4'd5) ? dig_reg[i] + 4'd3 : dig_reg[i];
        end
        dig_step[0] = is_oct ? {1'b0, adj[0][1:0], mag_reg[ita_pkg::WORD_BITS-1]}
                             : {adj[0][2:0], mag_reg[ita_pkg::WORD_BITS-1]};
        for (int i = 1; i < ita_pkg::NDIG; i++)
        begin
            dig_step[i] = is_oct ? {1'b0, adj[i][1:0], adj[i-1][2]}
                                 : {adj[i][2:0], adj[i-1][3]};
        end
    end

    // Move all digits one place toward the top
    always_comb
    begin
        dig_up[0] = 4'd0;
        for (int i = 1; i < ita_pkg::NDIG; i++)
        begin
            dig_up[i] = dig_reg[i-1];
        end
    end

    assign norm_done = (dig_reg[ita_pkg::NDIG-1] != 4'd0)
                    || (lz_reg == ita_pkg::LZ_W'(ita_pkg::NDIG - 1));

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        lz_next      = lz_reg;
        mag_next     = mag_reg;
        dig_next     = dig_reg;
        case (state_reg)
            CV_IDLE:
            begin
                if (accept)
                begin
                    mag_next     = neg ? (~mag_in + ita_pkg::WORD_BITS'(1)) : mag_in;
                    bit_cnt_next = ita_pkg::BIT_W'(ita_pkg::WORD_BITS - 1);
                    lz_next      = '0;
                    for (int i = 0; i < ita_pkg::NDIG; i++)
                    begin
                        dig_next[i] = 4'd0;
                    end
                    state_next   = CV_CONV;
                end
            end
            CV_CONV:
            begin
                dig_next     = dig_step;
                mag_next     = {mag_reg[ita_pkg::WORD_BITS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - ita_pkg::BIT_W'(1);
                if (bit_cnt_reg == '0)
                begin
                    state_next = CV_NORM;
                end
            end
            CV_NORM:
            begin
                if (norm_done)
                begin
                    state_next = CV_WAIT;
                end
                else
                begin
                    dig_next = dig_up;
                    lz_next  = lz_reg + ita_pkg::LZ_W'(1);
                end
            end
            CV_WAIT:
            begin
                if (stat.pop)
                begin
                    dig_next = dig_up;
                end
                if (stat.done)
                begin
                    state_next = CV_IDLE;
                end
            end
            default:
            begin
                state_next = CV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath and item format, no reset
    always_ff @(posedge clk)
    begin
        bit_cnt_reg <= bit_cnt_next;
        lz_reg      <= lz_next;
        mag_reg     <= mag_next;
        dig_reg     <= dig_next;
        if (accept)
        begin
            sel_reg      <= din.base_select;
            width_reg    <= (din.min_width > 7'(ita_pkg::MAX_CHARS))
                            ? ita_pkg::CNT_W'(ita_pkg::MAX_CHARS)
                            : ita_pkg::CNT_W'(din.min_width);
            prec_reg     <= (din.min_digits > 6'(ita_pkg::MAX_PREC))
                            ? ita_pkg::PREC_W'(ita_pkg::MAX_PREC) : din.min_digits;
            left_reg     <= din.format_flags[ita_pkg::FL_LEFT];
            zero_reg     <= din.format_flags[ita_pkg::FL_ZERO]
                            && !din.format_flags[ita_pkg::FL_LEFT];
            lower_reg    <= din.format_flags[ita_pkg::FL_LOWER];
            has_sign_reg <= neg || din.format_flags[ita_pkg::FL_PLUS]
                            || din.format_flags[ita_pkg::FL_SPACE];
            sign_ch_reg  <= neg ? ita_pkg::CH_MINUS
                            : (din.format_flags[ita_pkg::FL_PLUS] ? ita_pkg::CH_PLUS
                                                                  : ita_pkg::CH_SPACE);
            fmt_pref_reg <= din.format_flags[ita_pkg::FL_PREF];
        end
    end

    // Prefix length follows the latched radix
    always_comb
    begin
        pre_len = 2'd0;
        if (fmt_pref_reg)
        begin
            pre_len = is_hex ? 2'd2 : (is_oct ? 2'd1 : 2'd0);
        end
    end

    // Hand the item to the emitter
    assign fmt.start     = (state_reg == CV_NORM) && norm_done;
    assign fmt.nd        = ita_pkg::ND_W'(ita_pkg::NDIG) - ita_pkg::ND_W'(lz_reg);
    assign fmt.width     = width_reg;
    assign fmt.prec      = prec_reg;
    assign fmt.zero_pad  = zero_reg;
    assign fmt.left      = left_reg;
    assign fmt.lower     = lower_reg;
    assign fmt.has_sign  = has_sign_reg;
    assign fmt.sign_ch   = sign_ch_reg;
    assign fmt.pre_len   = pre_len;
    assign fmt.top_digit = dig_reg[ita_pkg::NDIG-1];

endmodule

/* rtl/ita_emit.sv */
module ita_emit
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  ita_pkg::ita_fmt_t         fmt,
    output ita_pkg::ita_emit_stat_t   stat,
    ita_out_if.source                 dout
);

    localparam int PH_W = 3;
    localparam int NPH  = 8;

    localparam logic [PH_W-1:0] PH_LEAD  = 3'd0;
    localparam logic [PH_W-1:0] PH_SIGN  = 3'd1;
    localparam logic [PH_W-1:0] PH_PRE0  = 3'd2;
    localparam logic [PH_W-1:0] PH_PREX  = 3'd3;
    localparam logic [PH_W-1:0] PH_ZPAD  = 3'd4;
    localparam logic [PH_W-1:0] PH_PREC  = 3'd5;
    localparam logic [PH_W-1:0] PH_DIG   = 3'd6;
    localparam logic [PH_W-1:0] PH_TRAIL = 3'd7;

    localparam int CW = ita_pkg::CNT_W;

    logic                      busy_reg, busy_next;
    logic [PH_W-1:0]           phase_reg, phase_next;
    logic [CW-1:0]             rem_reg, rem_next;
    logic [NPH-1:0][CW-1:0]    lens_reg, lens_next;
    logic                      lower_reg;
    logic [7:0]                sign_ch_reg;
    logic                      ov_reg, ov_next;
    logic [7:0]                oc_reg;
    logic                      ol_reg;

    logic [CW-1:0]             nd_w, prec_w, prec_eff, pad;
    logic [CW:0]               body;
    logic [NPH-1:0][CW-1:0]    lens_init;
    logic [PH_W:0]             first_ph, after_ph;
    logic                      fire, last;
    logic [7:0]                ch;

    // Lowest phase at or after from that still has characters; NPH when none
    function automatic logic [PH_W:0] pick_phase(input logic [NPH-1:0][CW-1:0] lens,
                                                 input logic [PH_W:0] from);
        logic [PH_W:0] r;
        r = (PH_W+1)'(NPH);
        for (int p = NPH - 1; p >= 0; p--)
        begin
            if (((PH_W+1)'(p) >= from) && (lens[p] != '0))
            begin
                r = (PH_W+1)'(p);
            end
        end
        return r;
    endfunction

    // Segment lengths of the text
    always_comb
    begin
        nd_w     = CW'(fmt.nd);
        prec_w   = CW'(fmt.prec);
        prec_eff = (nd_w > prec_w) ? nd_w : prec_w;
        body     = {1'b0, prec_eff} + (CW+1)'(fmt.pre_len) + (CW+1)'(fmt.has_sign);
        pad      = ({1'b0, fmt.width} > body) ? CW'({1'b0, fmt.width} - body) : '0;
        lens_init[PH_LEAD]  = (!fmt.zero_pad && !fmt.left) ? pad : '0;
        lens_init[PH_SIGN]  = CW'(fmt.has_sign);
        lens_init[PH_PRE0]  = CW'(fmt.pre_len != 2'd0);
        lens_init[PH_PREX]  = CW'(fmt.pre_len == 2'd2);
        lens_init[PH_ZPAD]  = fmt.zero_pad ? pad : '0;
        lens_init[PH_PREC]  = prec_eff - nd_w;
        lens_init[PH_DIG]   = nd_w;
        lens_init[PH_TRAIL] = fmt.left ? pad : '0;
    end

    assign first_ph = pick_phase(lens_init, '0);
    assign after_ph = pick_phase(lens_reg, {1'b0, phase_reg} + (PH_W+1)'(1));

    assign fire = busy_reg && (!ov_reg || dout.ready);
    assign last = (rem_reg == CW'(1)) && after_ph[PH_W];

    // Character of the current phase
    always_comb
    begin
        case (phase_reg)
            PH_LEAD:  ch = ita_pkg::CH_SPACE;
            PH_SIGN:  ch = sign_ch_reg;
            PH_PRE0:  ch = ita_pkg::CH_ZERO;
            PH_PREX:  ch = lower_reg ? ita_pkg::CH_LO_X : ita_pkg::CH_UP_X;
            PH_ZPAD:  ch = ita_pkg::CH_ZERO;
            PH_PREC:  ch = ita_pkg::CH_ZERO;
            PH_DIG:   ch = ita_pkg::digit_char(fmt.top_digit, lower_reg);
            PH_TRAIL: ch = ita_pkg::CH_SPACE;
            default:  ch = ita_pkg::CH_SPACE;
        endcase
    end

    // Phase sequencer
    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        rem_next   = rem_reg;
        lens_next  = lens_reg;
        ov_next    = ov_reg && !dout.ready;
        if (fmt.start)
        begin
            busy_next  = 1'b1;
            lens_next  = lens_init;
            phase_next = first_ph[PH_W-1:0];
            rem_next   = lens_init[first_ph[PH_W-1:0]];
        end
        else if (fire)
        begin
            ov_next = 1'b1;
            if (rem_reg == CW'(1))
            begin
                if (after_ph[PH_W])
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    phase_next = after_ph[PH_W-1:0];
                    rem_next   = lens_reg[after_ph[PH_W-1:0]];
                end
            end
            else
            begin
                rem_next = rem_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        rem_reg   <= rem_next;
        lens_reg  <= lens_next;
        if (fmt.start)
        begin
            lower_reg   <= fmt.lower;
            sign_ch_reg <= fmt.sign_ch;
        end
        if (fire)
        begin
            oc_reg <= ch;
            ol_reg <= last;
        end
    end

    assign stat.pop  = fire && (phase_reg == PH_DIG);
    assign stat.done = fire && last;

    assign dout.valid     = ov_reg;
    assign dout.out_char  = oc_reg;
    assign dout.last_char = ol_reg;

endmodule

/* rtl/integer_to_ascii_formatter.sv */
// Printf-style integer formatter. One number is taken on din when the block is
// idle; its text leaves on dout one character per item, the last one marked by
// last_char. An item goes through bit-serial radix conversion (one magnitude
// bit shifted into the digit register per cycle, shift-and-add-3 for decimal),
// then a shift that drops leading zero digits (at most NDIG-1 of them), then
// the sizing of the fields, then its characters, one per cycle out of the output
// register when dout is not stalled. The next number is accepted once the last
// character of the current one is in the output register.
module integer_to_ascii_formatter
(
    input  logic      clk,
    input  logic      rst_n,
    ita_in_if.sink    din,
    ita_out_if.source dout
);

    ita_pkg::ita_fmt_t       fmt;
    ita_pkg::ita_emit_stat_t stat;

    // Radix conversion and digit store
    ita_convert u_convert
    (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din),
        .stat  (stat),
        .fmt   (fmt)
    );

    // Padding, sign, prefix and character output
    ita_emit u_emit
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fmt   (fmt),
        .stat  (stat),
        .dout  (dout)
    );

endmodule

/* tb/integer_to_ascii_formatter_tb.sv */
`timescale 1ns / 100ps

module integer_to_ascii_formatter_tb;

    // Flag masks built from the package bit positions
    localparam logic [6:0] F_ZERO  = 7'(1) << ita_pkg::FL_ZERO;
    localparam logic [6:0] F_SIGN  = 7'(1) << ita_pkg::FL_SIGN;
    localparam logic [6:0] F_PLUS  = 7'(1) << ita_pkg::FL_PLUS;
    localparam logic [6:0] F_SPACE = 7'(1) << ita_pkg::FL_SPACE;
    localparam logic [6:0] F_LEFT  = 7'(1) << ita_pkg::FL_LEFT;
    localparam logic [6:0] F_PREF  = 7'(1) << ita_pkg::FL_PREF;
    localparam logic [6:0] F_LOWER = 7'(1) << ita_pkg::FL_LOWER;
    localparam logic [6:0] F_ALL   = 7'h7F;

    localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [1:0]  BASE_ALT = 2'd3;   // unused radix code, acts as hex

    localparam int SETTLE_CYCLES = 200;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_BURSTY} rx_mode_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    logic clk = 1'b0;
    logic rst_n;

    ita_in_if  num_if();
    ita_out_if char_if();

    integer_to_ascii_formatter uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (num_if),
        .dout  (char_if)
    );

    text_char_t pending_text[$];

    int       numbers_sent;
    int       chars_checked;
    int       mismatches;
    int       burst_left;
    int       burst_max;
    int       gap_max;
    int       stall_left;
    rx_mode_t rx_mode;

    // Clock, 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Printf-style text for one number, appended to the pending text
    task automatic predict_text(input logic [63:0] num, input logic [1:0] radix_sel,
                                input logic [6:0] fw, input logic [5:0] md,
                                input logic [6:0] fl);
        logic [63:0] mag;
        logic [63:0] radix;
        logic [6:0]  flags;
        logic [3:0]  d;
        logic [7:0]  sign_ch;
        logic        has_sign;
        logic [7:0]  digs[64];
        logic [7:0]  text[$];
        int          width;
        int          prec;
        int          nd;
        int          pad;
        int          pre_len;
        int          k;
        text_char_t  tc;

        flags = fl;
        width = (fw > ita_pkg::MAX_CHARS) ? ita_pkg::MAX_CHARS : int'(fw);
        prec  = (md > ita_pkg::MAX_PREC) ? ita_pkg::MAX_PREC : int'(md);
        if (flags[ita_pkg::FL_LEFT])
            flags[ita_pkg::FL_ZERO] = 1'b0;
        radix = (radix_sel == ita_pkg::BASE_OCT) ? 64'd8
              : ((radix_sel == ita_pkg::BASE_DEC) ? 64'd10 : 64'd16);

        // Sign choice
        mag      = num;
        has_sign = 1'b0;
        sign_ch  = ita_pkg::CH_SPACE;
        if (flags[ita_pkg::FL_SIGN] && mag[63])
        begin
            has_sign = 1'b1;
            sign_ch  = ita_pkg::CH_MINUS;
            mag      = ~mag + 64'd1;
        end
        else if (flags[ita_pkg::FL_PLUS])
        begin
            has_sign = 1'b1;
            sign_ch  = ita_pkg::CH_PLUS;
        end
        else if (flags[ita_pkg::FL_SPACE])
        begin
            has_sign = 1'b1;
        end

        pre_len = 0;
        if (flags[ita_pkg::FL_PREF])
            pre_len = (radix == 64'd16) ? 2 : ((radix == 64'd8) ? 1 : 0);

        // Digits, least significant first
        nd = 0;
        if (mag == 64'd0)
        begin
            digs[0] = ita_pkg::CH_ZERO;
            nd = 1;
        end
        else
        begin
            while (mag != 64'd0 && nd < 64)
            begin
                d = 4'(mag % radix);
                if (d < 4'd10)
                    digs[nd] = ita_pkg::CH_ZERO + 8'(d);
                else
                    digs[nd] = (flags[ita_pkg::FL_LOWER] ? ita_pkg::CH_LO_A : ita_pkg::CH_UP_A)
                               + 8'(d) - 8'd10;
                nd++;
                mag = mag / radix;
            end
        end
        if (nd > prec)
            prec = nd;

        pad = width - (has_sign ? 1 : 0) - pre_len - prec;
        if (pad < 0)
            pad = 0;

        // Assemble the text
        if (!flags[ita_pkg::FL_ZERO] && !flags[ita_pkg::FL_LEFT])
        begin
            for (k = 0; k < pad; k++)
                text.push_back(ita_pkg::CH_SPACE);
            pad = 0;
        end
        if (has_sign)
            text.push_back(sign_ch);
        if (pre_len >= 1)
            text.push_back(ita_pkg::CH_ZERO);
        if (pre_len == 2)
            text.push_back(flags[ita_pkg::FL_LOWER] ? ita_pkg::CH_LO_X : ita_pkg::CH_UP_X);
        if (!flags[ita_pkg::FL_LEFT])
        begin
            for (k = 0; k < pad; k++)
                text.push_back(ita_pkg::CH_ZERO);
            pad = 0;
        end
        for (k = nd; k < prec; k++)
            text.push_back(ita_pkg::CH_ZERO);
        for (k = nd - 1; k >= 0; k--)
            text.push_back(digs[k]);
        for (k = 0; k < pad; k++)
            text.push_back(ita_pkg::CH_SPACE);

        while (text.size() > ita_pkg::MAX_CHARS)
            void'(text.pop_back());
        for (k = 0; k < text.size(); k++)
        begin
            tc.ch   = text[k];
            tc.last = (k == text.size() - 1);
            pending_text.push_back(tc);
        end
    endtask

    // Send one number; valid stays high across a burst
    task automatic send_number(input logic [63:0] num, input logic [1:0] radix_sel,
                               input logic [6:0] fw, input logic [5:0] md,
                               input logic [6:0] fl);
        @(negedge clk);
        num_if.valid        = 1'b1;
        num_if.value        = num;
        num_if.base_select  = radix_sel;
        num_if.min_width    = fw;
        num_if.min_digits   = md;
        num_if.format_flags = fl;
        do
            @(posedge clk);
        while (!num_if.ready);
        predict_text(num, radix_sel, fw, md, fl);
        numbers_sent++;

        // Burst bookkeeping and gap
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else if (gap_max > 0)
        begin
            @(negedge clk);
            num_if.valid = 1'b0;
            repeat ($urandom_range(0, gap_max)) @(negedge clk);
            burst_left = $urandom_range(0, burst_max);
        end
    endtask

    // One number with random content, biased toward small sizes
    task automatic send_random_number();
        logic [63:0] num;
        logic [6:0]  fw;
        logic [5:0]  md;
        int          pick;

        case ($urandom_range(0, 5))
            0: num = {$urandom, $urandom};
            1: num = 64'($urandom_range(0, 255));
            2: num = 64'd0 - 64'($urandom_range(1, 300));
            3: num = {$urandom, $urandom} >> $urandom_range(0, 63);
            4: num = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
            default:
            begin
                pick = $urandom_range(0, 3);
                num = (pick == 0) ? 64'd0 : (pick == 1) ? '1 :
                      (pick == 2) ? MOST_NEG : MOST_POS;
            end
        endcase

        pick = $urandom_range(0, 99);
        if (pick < 65)
            fw = 7'($urandom_range(0, 16));
        else if (pick < 85)
            fw = 7'($urandom_range(17, 64));
        else
            fw = 7'($urandom_range(65, 127));

        pick = $urandom_range(0, 99);
        if (pick < 70)
            md = 6'($urandom_range(0, 8));
        else if (pick < 90)
            md = 6'($urandom_range(9, 40));
        else
            md = 6'($urandom_range(41, 63));

        send_number(num, 2'($urandom_range(0, 3)), fw, md, 7'($urandom_range(0, 127)));
    endtask

    // Receiver ready pattern
    always @(negedge clk)
    begin
        case (rx_mode)
            RX_OPEN:
                char_if.ready <= 1'b1;
            RX_RANDOM:
                char_if.ready <= ($urandom_range(0, 3) != 0);
            default:
            begin
                if (stall_left > 0)
                begin
                    char_if.ready <= 1'b0;
                    stall_left--;
                end
                else if ($urandom_range(0, 15) == 0)
                begin
                    char_if.ready <= 1'b0;
                    stall_left = $urandom_range(0, 8);
                end
                else
                begin
                    char_if.ready <= 1'b1;
                end
            end
        endcase
    end

    // Compare each character with the oldest pending one
    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n && char_if.valid && char_if.ready)
        begin
            if (pending_text.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected char 0x%02h last %0b", $realtime,
                             char_if.out_char, char_if.last_char);
            end
            else
            begin
                want = pending_text.pop_front();
                chars_checked++;
                if (char_if.out_char !== want.ch || char_if.last_char !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: char exp 0x%02h last %0b, got 0x%02h last %0b",
                                 $realtime, want.ch, want.last,
                                 char_if.out_char, char_if.last_char);
                end
            end
        end
    end

    // Extremes, every radix and flag, and the corner cases
    task automatic test_directed_cases();
        burst_max = 3;
        gap_max   = 6;
        rx_mode   = RX_RANDOM;
        send_number(64'd0, ita_pkg::BASE_DEC, 7'd0, 6'd0, 7'd0);
        send_number(64'd0, ita_pkg::BASE_HEX, 7'd0, 6'd0, F_PREF);
        send_number(64'd0, ita_pkg::BASE_OCT, 7'd0, 6'd0, F_PREF);
        send_number('1, ita_pkg::BASE_HEX, 7'd0, 6'd0, F_LOWER | F_PREF);
        send_number('1, ita_pkg::BASE_DEC, 7'd0, 6'd0, 7'd0);
        send_number('1, ita_pkg::BASE_OCT, 7'd0, 6'd0, F_PREF);
        send_number(MOST_NEG, ita_pkg::BASE_DEC, 7'd0, 6'd0, F_SIGN);
        send_number('1, ita_pkg::BASE_DEC, 7'd5, 6'd0, F_SIGN);
        send_number(64'd42, ita_pkg::BASE_DEC, 7'd0, 6'd0, F_PLUS);
        send_number(64'd42, ita_pkg::BASE_DEC, 7'd6, 6'd0, F_SPACE);
        send_number(64'd42, ita_pkg::BASE_DEC, 7'd0, 6'd0, F_PLUS | F_SPACE);
        // left justify cancels zero pad
        send_number(64'd42, ita_pkg::BASE_DEC, 7'd8, 6'd0, F_LEFT | F_ZERO);
        send_number(64'd42, ita_pkg::BASE_DEC, 7'd8, 6'd0, F_ZERO | F_PLUS);
        send_number(64'd255, BASE_ALT, 7'd0, 6'd0, F_PREF);
        // width and digit count saturation
        send_number(64'd7, ita_pkg::BASE_HEX, 7'd127, 6'd0, 7'd0);
        send_number(64'd7, ita_pkg::BASE_DEC, 7'd0, 6'd63, 7'd0);
        send_number(MOST_NEG, ita_pkg::BASE_HEX, 7'd0, 6'd63, F_SIGN | F_PREF | F_LOWER);
        send_number(64'd123, ita_pkg::BASE_DEC, 7'd10, 6'd5, F_ZERO);
        send_number(64'd123, ita_pkg::BASE_OCT, 7'd10, 6'd0, F_ZERO | F_PREF);
        send_number(64'hDEAD_BEEF, ita_pkg::BASE_HEX, 7'd20, 6'd0,
                    F_LEFT | F_PREF | F_PLUS);
        send_number(64'hABCD_EF01, ita_pkg::BASE_HEX, 7'd0, 6'd0, F_LOWER);
        send_number(64'hABCD_EF01, ita_pkg::BASE_HEX, 7'd0, 6'd0, 7'd0);
        send_number(64'd5, ita_pkg::BASE_DEC, 7'd64, 6'd0, F_LEFT);
        send_number(MOST_NEG, ita_pkg::BASE_OCT, 7'd30, 6'd0, F_ALL);
        send_number(MOST_POS, ita_pkg::BASE_DEC, 7'd0, 6'd0, F_SIGN | F_SPACE);
    endtask

    // Random numbers with sender gaps and random receiver stalls
    task automatic test_random_mixed(input int count);
        burst_max = 4;
        gap_max   = 120;
        rx_mode   = RX_RANDOM;
        repeat (count) send_random_number();
    endtask

    // Random numbers against long receiver stalls
    task automatic test_receiver_stalls(input int count);
        burst_max = 2;
        gap_max   = 40;
        rx_mode   = RX_BURSTY;
        repeat (count) send_random_number();
    endtask

    // Random numbers with no idling on either side
    task automatic test_back_to_back(input int count);
        gap_max    = 0;
        burst_left = 0;
        rx_mode    = RX_OPEN;
        repeat (count) send_random_number();
    endtask

    initial
    begin
        rst_n               = 1'b0;
        num_if.valid        = 1'b0;
        num_if.value        = '0;
        num_if.base_select  = ita_pkg::BASE_OCT;
        num_if.min_width    = '0;
        num_if.min_digits   = '0;
        num_if.format_flags = '0;
        char_if.ready       = 1'b0;
        rx_mode             = RX_OPEN;
        numbers_sent        = 0;
        chars_checked       = 0;
        mismatches          = 0;
        burst_left          = 0;
        burst_max           = 1;
        gap_max             = 0;
        stall_left          = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_random_mixed(235);
        test_receiver_stalls(120);
        test_back_to_back(80);

        @(negedge clk);
        num_if.valid = 1'b0;
        rx_mode      = RX_RANDOM;
        wait (pending_text.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Formatted %0d numbers, %0d characters checked, %0d mismatches",
                 numbers_sent, chars_checked, mismatches);
        $display("Covered all radix codes, flag sets, saturated widths and receiver stalls");
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Guard against a hang
    initial
    begin
        #5_000_000;
        $display("Timeout with %0d characters still pending", pending_text.size());
        $display("Verification failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/ita_pkg.sv
rtl/ita_in_if.sv
rtl/ita_out_if.sv
rtl/ita_convert.sv
rtl/ita_emit.sv
rtl/integer_to_ascii_formatter.sv
tb/integer_to_ascii_formatter_tb.sv
